// ----- rtl/core/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the serial line editor: item codes, character
// codes, register map and the result descriptor passed between stages.
// ----------------------------------------------------------------------------
package sle_pkg;

	// Default size of the line store in bytes
	localparam int unsigned LINE_LEN_DEF = 1024;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned LEN_W   = 10;
	localparam int unsigned SLOTS   = 3;
	localparam int unsigned CNT_W   = 2;

	// Stream packing: tdata holds the byte and the index / length
	localparam int unsigned TDATA_W = 24;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

	// Register map (register index taken from paddr[2])
	localparam int unsigned PADDR_W  = 3;
	localparam logic        REG_ECHO = 1'b0;
	localparam logic        REG_EOL  = 1'b1;

	// End-of-line echo modes
	localparam logic [1:0] EOL_CRLF = 2'd0;
	localparam logic [1:0] EOL_LF   = 2'd1;
	localparam logic [1:0] EOL_CR   = 2'd2;

	// Input item codes
	typedef enum logic [1:0] {
		OP_RX      = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	// Result item kinds
	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	// Results caused by one input item
	typedef struct packed {
		logic [CNT_W-1:0]             count;
		kind_t [SLOTS-1:0]            kinds;
		logic [SLOTS-1:0][BYTE_W-1:0] bytes;
		logic [LEN_W-1:0]             length;
		logic                         rd_zero;
	} res_desc_t;

endpackage

// ----- rtl/core/serial_line_editor.sv -----
// Latency: the first result of an item passes the stage 1 item register and then the result
// register; further results follow one per cycle while m_tready is high. Throughput: one item
// per cycle when each causes at most one result and the output does not stall; an item with
// several results holds the result register until its last is taken (up to 3, backspace or end of line with echo).
// Reset: arst_n clears line state, stage valids and registers; the line store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// serial_line_editor
// Command-line editor for received serial bytes with backspace and echo,
// line read-back and an APB register port.
// ----------------------------------------------------------------------------
module serial_line_editor #(
	parameter int unsigned LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sle_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sle_pkg::TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte, [17:8] read_index
	input  logic [1:0]                   s_tuser,  // [1:0] opcode
	// Output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sle_pkg::TDATA_W-1:0]  m_tdata,  // [7:0] out_byte, [17:8] line_length
	output logic [1:0]                   m_tuser,  // [1:0] kind
	output logic                         m_tlast
);

	import sle_pkg::*;

	localparam int unsigned ADDR_W = $clog2(LINE_LEN);

	logic              echo_en_q;
	logic [1:0]        eol_mode_q;
	logic              cfg_wr;

	logic              take_ok;
	logic              desc_valid;
	res_desc_t         desc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	kind_t             out_kind;
	logic [BYTE_W-1:0] out_byte;
	logic [LEN_W-1:0]  out_length;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q  <= 1'b0;
			eol_mode_q <= EOL_CRLF;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ECHO) begin
				echo_en_q <= pwdata[0];
			end else begin
				eol_mode_q <= pwdata[1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ECHO) begin
			prdata[0] = echo_en_q;
		end else begin
			prdata[1:0] = eol_mode_q;
		end
	end

	sle_edit #(
		.LINE_LEN(LINE_LEN)
	) u_edit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser)),
		.in_byte   (s_tdata[BYTE_W-1:0]),
		.in_index  (s_tdata[BYTE_W+INDEX_W-1:BYTE_W]),
		.echo_en   (echo_en_q),
		.eol_mode  (eol_mode_q),
		.take_ok   (take_ok),
		.desc_valid(desc_valid),
		.desc      (desc),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	sle_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_LEN)
	) u_line_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sle_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc      (desc),
		.take_ok   (take_ok),
		.rd_byte   (mem_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_length(out_length),
		.out_last  (m_tlast)
	);

	// Pack the result item
	assign m_tuser = out_kind;
	assign m_tdata = {{(TDATA_W - BYTE_W - LEN_W){1'b0}}, out_length, out_byte};

endmodule

// ----- rtl/core/sle_ram.sv -----
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/sle_edit.sv -----
// ----------------------------------------------------------------------------
// sle_edit
// Input register and line editing: holds one item, applies it to the line
// state and store, and hands the results it causes to the emitter.
// ----------------------------------------------------------------------------
module sle_edit #(
	parameter int unsigned LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sle_pkg::op_t                  in_op,
	input  logic [sle_pkg::BYTE_W-1:0]    in_byte,
	input  logic [sle_pkg::INDEX_W-1:0]   in_index,
	// Configuration
	input  logic                          echo_en,
	input  logic [1:0]                    eol_mode,
	// Emitter side
	input  logic                          take_ok,
	output logic                          desc_valid,
	output sle_pkg::res_desc_t            desc,
	// Line store ports
	output logic                          mem_we,
	output logic [$clog2(LINE_LEN)-1:0]   mem_waddr,
	output logic [sle_pkg::BYTE_W-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic [$clog2(LINE_LEN)-1:0]   mem_raddr
);

	import sle_pkg::*;

	localparam int unsigned ADDR_W = $clog2(LINE_LEN);
	localparam int unsigned WI_W   = $clog2(LINE_LEN + 1);
	localparam int unsigned CMP_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

	// Stage 1 item register
	logic               valid_s1;
	op_t                op_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [INDEX_W-1:0] index_s1;

	// Line state
	logic [WI_W-1:0]   wi_q;
	logic              ready_q;
	logic [ADDR_W-1:0] held_q;

	logic [WI_W-1:0]   wi_d;
	logic              ready_d;
	logic [ADDR_W-1:0] held_d;
	logic              adv;
	logic              not_full;
	logic [WI_W-1:0]   wi_inc;
	logic [CMP_W-1:0]  index_ext;
	logic [CMP_W-1:0]  held_ext;
	logic [CMP_W-1:0]  held_new_ext;
	res_desc_t         desc_d;

	assign adv      = valid_s1 && take_ok;
	assign in_ready = !valid_s1 || adv;

	assign not_full  = (wi_q < WI_W'(LINE_LEN));
	assign wi_inc    = not_full ? (wi_q + WI_W'(1)) : wi_q;
	assign index_ext = CMP_W'(index_s1);
	assign held_ext  = CMP_W'(held_q);

	// Store writes and reads happen once, as the item leaves stage 1
	assign mem_waddr = wi_q[ADDR_W-1:0];
	assign mem_wdata = byte_s1;
	assign mem_raddr = index_ext[ADDR_W-1:0];
	assign mem_re    = adv && (op_s1 == OP_READ);
	assign mem_we    = adv && (op_s1 == OP_RX) && !ready_q && (byte_s1 != CH_BS) && not_full;

	// Edit the line and build the result list
	always_comb begin
		wi_d         = wi_q;
		ready_d      = ready_q;
		held_d       = held_q;
		held_new_ext = CMP_W'(wi_inc - WI_W'(1));
		desc_d       = '0;
		case (op_s1)
			OP_READ: begin
				desc_d.count    = CNT_W'(1);
				desc_d.kinds[0] = KIND_READ;
				desc_d.rd_zero  = !(index_ext < held_ext);
			end
			OP_RELEASE: begin
				ready_d = 1'b0;
				wi_d    = '0;
			end
			OP_RX: begin
				if (!ready_q) begin
					if (byte_s1 == CH_BS) begin
						if (wi_q != '0) begin
							wi_d = wi_q - WI_W'(1);
						end
						if (echo_en) begin
							desc_d.count    = CNT_W'(3);
							desc_d.kinds[0] = KIND_ECHO;
							desc_d.kinds[1] = KIND_ECHO;
							desc_d.kinds[2] = KIND_ECHO;
							desc_d.bytes[0] = CH_BS;
							desc_d.bytes[1] = CH_SP;
							desc_d.bytes[2] = CH_BS;
						end
					end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						wi_d    = wi_inc;
						ready_d = 1'b1;
						if (wi_inc == '0) begin
							held_new_ext = '0;
						end
						held_d = held_new_ext[ADDR_W-1:0];
						if (!echo_en) begin
							desc_d.count    = CNT_W'(1);
							desc_d.kinds[0] = KIND_LINE;
							desc_d.length   = held_new_ext[LEN_W-1:0];
						end else if (eol_mode == EOL_LF || eol_mode == EOL_CR) begin
							desc_d.count    = CNT_W'(2);
							desc_d.kinds[0] = KIND_ECHO;
							desc_d.bytes[0] = (eol_mode == EOL_LF) ? CH_LF : CH_CR;
							desc_d.kinds[1] = KIND_LINE;
							desc_d.length   = held_new_ext[LEN_W-1:0];
						end else begin
							desc_d.count    = CNT_W'(3);
							desc_d.kinds[0] = KIND_ECHO;
							desc_d.bytes[0] = CH_CR;
							desc_d.kinds[1] = KIND_ECHO;
							desc_d.bytes[1] = CH_LF;
							desc_d.kinds[2] = KIND_LINE;
							desc_d.length   = held_new_ext[LEN_W-1:0];
						end
					end else begin
						wi_d = wi_inc;
						if (echo_en) begin
							desc_d.count    = CNT_W'(1);
							desc_d.kinds[0] = KIND_ECHO;
							desc_d.bytes[0] = byte_s1;
						end
					end
				end
			end
			default: begin
				desc_d = '0;
			end
		endcase
	end

	assign desc       = desc_d;
	assign desc_valid = adv && (desc_d.count != '0);

	// Hold stage 1 valid and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wi_q     <= '0;
			ready_q  <= 1'b0;
			held_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				wi_q    <= wi_d;
				ready_q <= ready_d;
				held_q  <= held_d;
			end
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= in_op;
			byte_s1  <= in_byte;
			index_s1 <= in_index;
		end
	end

`ifndef ASSERT_OFF
	a_wi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= WI_W'(LINE_LEN))
		else $error("write index past line size");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == OP_RELEASE |=> !ready_q && wi_q == '0)
		else $error("release did not clear line state");

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == OP_RX && ready_q |-> !mem_we && !desc_valid)
		else $error("byte not dropped while line ready");
`endif

endmodule

// ----- rtl/core/sle_emit.sv -----
// ----------------------------------------------------------------------------
// sle_emit
// Result register: holds the results of one item and presents them one per
// cycle on the output stream while out_ready is high, marking the final one.
// ----------------------------------------------------------------------------
module sle_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	// From the editor
	input  logic                         desc_valid,
	input  sle_pkg::res_desc_t           desc,
	output logic                         take_ok,
	input  logic [sle_pkg::BYTE_W-1:0]   rd_byte,
	// Result output
	output logic                         out_valid,
	input  logic                         out_ready,
	output sle_pkg::kind_t               out_kind,
	output logic [sle_pkg::BYTE_W-1:0]   out_byte,
	output logic [sle_pkg::LEN_W-1:0]    out_length,
	output logic                         out_last
);

	import sle_pkg::*;

	logic             valid_s2;
	res_desc_t        desc_s2;
	logic [CNT_W-1:0] cnt_q;
	logic             fire;

	assign out_valid = valid_s2;
	assign out_kind  = desc_s2.kinds[cnt_q];
	assign out_last  = (cnt_q == desc_s2.count - CNT_W'(1));
	assign fire      = valid_s2 && out_ready;
	assign take_ok   = !valid_s2 || (out_ready && out_last);

	// Select the byte and length of the current result
	always_comb begin
		out_byte   = '0;
		out_length = '0;
		case (out_kind)
			KIND_ECHO: out_byte = desc_s2.bytes[cnt_q];
			KIND_LINE: out_length = desc_s2.length;
			KIND_READ: out_byte = desc_s2.rd_zero ? '0 : rd_byte;
			default:   out_byte = '0;
		endcase
	end

	// Advance through the results, load the next item's list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (take_ok) begin
				valid_s2 <= desc_valid;
				cnt_q    <= '0;
			end else if (fire) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_ok && desc_valid) begin
			desc_s2 <= desc;
		end
	end

`ifndef ASSERT_OFF
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> desc_s2.count != '0)
		else $error("empty result list held");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> cnt_q < desc_s2.count)
		else $error("result counter past list");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !out_last |=> valid_s2 && cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("result counter did not advance");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the serial line editor. An initial block queues
// directed and random command items and moves the register settings between
// phases; a clocked driver offers the items with random gaps, and at each
// accepted item a line-editing predictor works out the echo, line and
// read-back results. A clocked monitor stalls at random, once for a long
// stretch, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import sle_pkg::*;

	localparam int unsigned    LINE_LEN     = LINE_LEN_DEF;
	localparam int unsigned    CHOKE_CYCLES = 400;
	localparam logic [1:0]     OP_SPARE     = 2'd3;
	localparam logic [1:0]     EOL_SPARE    = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_ECHO = {REG_ECHO, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_EOL  = {REG_EOL, 2'b00};

	typedef struct {
		logic [1:0]         opcode;
		logic [BYTE_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
	} cmd_t;

	typedef struct {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] ch;
		logic [LEN_W-1:0]  len;
		logic              last;
	} line_out_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata  = '0;  // [7:0] rx_byte, [17:8] read_index
	logic [1:0]          s_tuser  = '0;  // [1:0] opcode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;        // [7:0] out_byte, [17:8] line_length
	logic [1:0]          m_tuser;        // [1:0] kind
	logic                m_tlast;

	// Editor state as predicted
	logic [BYTE_W-1:0] line_mem [0:LINE_LEN-1];
	int unsigned       fill_cnt;
	bit                line_done;
	logic [LEN_W-1:0]  done_len;
	bit                echo_on;
	logic [1:0]        eol_sel;

	cmd_t      host_cmds [$];
	line_out_t awaited_out [$];
	cmd_t      on_wire;
	line_out_t front_out;
	int        fails;
	int        send_wait;
	int        recv_wait;
	int        choke_left;
	bit        send_calm;
	bit        recv_calm;
	bit        choke_req;

	serial_line_editor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(bit calm);
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic line_out_t echo_of(logic [BYTE_W-1:0] ch);
		return '{KIND_ECHO, ch, '0, 1'b0};
	endfunction

	// Apply one accepted item to the predicted line and queue its results
	function automatic void edit_line(cmd_t c);
		line_out_t outs [$];
		if (c.opcode == OP_READ) begin
			outs.push_back('{KIND_READ, (c.idx < done_len) ? line_mem[c.idx] : 8'h00,
				'0, 1'b0});
		end else if (c.opcode == OP_RELEASE) begin
			line_done = 1'b0;
			fill_cnt  = 0;
		end else if (c.opcode == OP_RX && !line_done) begin
			if (c.ch == CH_BS) begin
				if (fill_cnt > 0)
					fill_cnt--;
				if (echo_on) begin
					outs.push_back(echo_of(CH_BS));
					outs.push_back(echo_of(CH_SP));
					outs.push_back(echo_of(CH_BS));
				end
			end else begin
				if (fill_cnt < LINE_LEN) begin
					line_mem[fill_cnt] = c.ch;
					fill_cnt++;
				end
				if (c.ch == CH_CR || c.ch == CH_LF) begin
					// a full store drops its last byte from the length
					done_len  = (fill_cnt > 0) ? LEN_W'(fill_cnt - 1) : '0;
					line_done = 1'b1;
					if (echo_on) begin
						case (eol_sel)
							EOL_LF: outs.push_back(echo_of(CH_LF));
							EOL_CR: outs.push_back(echo_of(CH_CR));
							default: begin
								outs.push_back(echo_of(CH_CR));
								outs.push_back(echo_of(CH_LF));
							end
						endcase
					end
					outs.push_back('{KIND_LINE, 8'h00, done_len, 1'b0});
				end else if (echo_on) begin
					outs.push_back(echo_of(c.ch));
				end
			end
		end
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			awaited_out.push_back(outs[i]);
	endfunction

	function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	function automatic void queue_cmd(logic [1:0] op, logic [BYTE_W-1:0] ch,
			logic [INDEX_W-1:0] idx);
		host_cmds.push_back('{op, ch, idx});
	endfunction

	// Fields an opcode does not use carry random noise
	function automatic void queue_rx(logic [BYTE_W-1:0] ch);
		queue_cmd(OP_RX, ch, INDEX_W'($urandom_range(0, 1023)));
	endfunction

	function automatic void queue_read(logic [INDEX_W-1:0] idx);
		queue_cmd(OP_READ, BYTE_W'($urandom_range(0, 255)), idx);
	endfunction

	function automatic void queue_release();
		queue_cmd(OP_RELEASE, BYTE_W'($urandom_range(0, 255)),
			INDEX_W'($urandom_range(0, 1023)));
	endfunction

	// Queue one command line with random content; return the items that count
	function automatic int queue_random_line();
		int body_len;
		int n;
		logic [BYTE_W-1:0] ch;
		n = 0;
		if ($urandom_range(0, 7) == 0)
			queue_cmd(OP_SPARE, BYTE_W'($urandom_range(0, 255)),
				INDEX_W'($urandom_range(0, 1023)));
		body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
		for (int i = 0; i < body_len; i++) begin
			ch = ($urandom_range(0, 7) == 0) ? CH_BS : 8'($urandom_range(0, 255));
			queue_rx(ch);
			// read back the previous line while this one overwrites it
			if ($urandom_range(0, 11) == 0)
				queue_read(INDEX_W'($urandom_range(0, 15)));
			n++;
		end
		// now and then leave the line unterminated
		if ($urandom_range(0, 9) != 0) begin
			queue_rx($urandom_range(0, 1) ? CH_CR : CH_LF);
			n++;
		end
		for (int i = $urandom_range(0, 3); i > 0; i--) begin
			queue_read(INDEX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) :
				$urandom_range(0, body_len + 1)));
			n++;
		end
		// bytes sent while a line waits are dropped
		if ($urandom_range(0, 7) == 0)
			queue_rx(BYTE_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 11) != 0) begin
			queue_release();
			n++;
		end
		return n;
	endfunction

	// Offer queued items; predict each one at the edge that takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				edit_line(on_wire);
				send_wait = draw_wait(send_calm);
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (host_cmds.size() > 0) begin
					on_wire = host_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(TDATA_W-INDEX_W-BYTE_W){1'b0}}, on_wire.idx, on_wire.ch};
					s_tuser  <= on_wire.opcode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Take results, compare with the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait  = 0;
			choke_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_out.size() == 0) begin
					$error("result with nothing awaited: kind %0d, byte %02h, length %0d",
						m_tuser, m_tdata[7:0], m_tdata[17:8]);
					fails++;
				end else begin
					front_out = awaited_out.pop_front();
					check_field("kind", 10'(front_out.kind), 10'(m_tuser));
					check_field("out_byte", 10'(front_out.ch), 10'(m_tdata[7:0]));
					check_field("line_length", front_out.len, m_tdata[17:8]);
					check_field("last", 10'(front_out.last), 10'(m_tlast));
				end
				recv_wait = draw_wait(recv_calm);
			end
			if (choke_req) begin
				choke_req  = 1'b0;
				choke_left = CHOKE_CYCLES;
			end
			if (choke_left > 0) begin
				choke_left--;
				m_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Wait until every item is taken and every result is in, then let stragglers pass
	task automatic settle();
		while (host_cmds.size() != 0 || s_tvalid || awaited_out.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_ECHO)
			echo_on = data[0];
		else
			eol_sel = data[1:0];
		@(negedge clk);
	endtask

	// Drain, move both registers, pick the idling style of the next phase
	task automatic begin_phase(bit echo, logic [1:0] eol);
		settle();
		reg_write(ADDR_ECHO, {31'b0, echo});
		reg_write(ADDR_EOL, {30'b0, eol});
		send_calm = ($urandom_range(0, 3) == 0);
		recv_calm = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int made;
		fails     = 0;
		fill_cnt  = 0;
		line_done = 1'b0;
		done_len  = '0;
		echo_on   = 1'b0;
		eol_sel   = EOL_CRLF;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		choke_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// echo off at reset: edits are silent, only the line result comes
		queue_rx(8'h41);
		queue_rx(8'hFF);
		queue_rx(CH_BS);
		queue_rx(8'h00);
		queue_rx(CH_CR);
		queue_rx(8'h5A);
		queue_read(10'd0);
		queue_read(10'd1);
		queue_read(10'h3FF);
		queue_release();

		// echo on: backspace on an empty line, spare opcode, release of a partial line
		begin_phase(1'b1, EOL_CRLF);
		queue_rx(CH_BS);
		queue_rx(8'h80);
		queue_rx(CH_LF);
		queue_read(10'd0);
		queue_cmd(OP_SPARE, 8'hC3, 10'h2A5);
		queue_release();
		queue_rx(8'h7F);
		queue_release();

		// each end-of-line echo, the spare mode included
		begin_phase(1'b1, EOL_LF);
		queue_rx(CH_CR);
		queue_release();
		begin_phase(1'b1, EOL_CR);
		queue_rx(8'h31);
		queue_rx(CH_LF);
		queue_release();
		begin_phase(1'b1, EOL_SPARE);
		queue_rx(CH_CR);
		queue_release();

		// random lines; the first phase holds the receiver off to back the block up
		for (int ph = 0; ph < 5; ph++) begin
			begin_phase((ph == 0) ? 1'b1 : 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)));
			if (ph == 0) begin
				send_calm = 1'b1;
				choke_req = 1'b1;
			end
			made = 0;
			while (made < 32)
				made += queue_random_line();
		end

		settle();
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
